/* rtl/audio_channel_remixer_unit_macros.svh */
`ifndef AUDIO_CHANNEL_REMIXER_UNIT_MACROS_SVH
`define AUDIO_CHANNEL_REMIXER_UNIT_MACROS_SVH

// Implication check, sampled on the rising clock edge, off during reset.
`define ACR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("acr assertion failed");

// Invariant check, sampled on the rising clock edge, off during reset.
`define ACR_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("acr assertion failed");

`endif

/* rtl/acr_pkg.sv */
package acr_pkg;

    localparam int NUM_CH       = 8;
    localparam int MAX_IN_CH    = 8;
    localparam int MAX_OUT_CH   = 8;
    localparam int SAMPLE_W     = 16;
    localparam int CNT_W        = 4;
    localparam int PAIR_W       = SAMPLE_W + 1;
    localparam int ACC_W        = SAMPLE_W + 3;
    localparam int MAG_W        = ACC_W + 1;
    localparam int DIV_W        = 4;
    localparam int RECIP_SHIFT  = 24;
    localparam int RECIP_W      = RECIP_SHIFT + 1;
    localparam int PROD_W       = MAG_W + RECIP_W;

    localparam logic [CNT_W-1:0] CNT_RESET = 4'd2;
    localparam logic [DIV_W-1:0] DIV_MAX   = 4'd8;

    // Configuration register indexes
    localparam logic CFG_IN_CHANNELS  = 1'b0;
    localparam logic CFG_OUT_CHANNELS = 1'b1;

    localparam logic [MAG_W-1:0] SAT_POS_MAG = 20'd32767;
    localparam logic [MAG_W-1:0] SAT_NEG_MAG = 20'd32768;
    localparam logic [SAMPLE_W-1:0] SAT_POS = 16'h7fff;
    localparam logic [SAMPLE_W-1:0] SAT_NEG = 16'h8000;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [ACC_W-1:0]    t_acc;

    // Mixing matrix decoded from the channel counts:
    // mask[k][j] adds input j into output k, div[k] divides output k.
    typedef struct packed {
        logic [NUM_CH-1:0][NUM_CH-1:0] mask;
        logic [NUM_CH-1:0][DIV_W-1:0]  div;
        logic [NUM_CH-1:0]             out_en;
    } t_mix_dec;

endpackage

/* rtl/acr_cfg.sv */
module acr_cfg import acr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CNT_W-1:0] i_cfg_data,
    output t_mix_dec         o_dec
);

    logic [CNT_W-1:0] r_in_ch;
    logic [CNT_W-1:0] r_out_ch;
    t_mix_dec         r_dec;
    t_mix_dec         n_dec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_ch  <= CNT_RESET;
            r_out_ch <= CNT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IN_CHANNELS:  r_in_ch  <= i_cfg_data;
                CFG_OUT_CHANNELS: r_out_ch <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        logic [CNT_W-1:0] nin;
        logic [CNT_W-1:0] nout;
        logic [DIV_W-1:0] q;
        logic [6:0]       even;
        logic             rem;
        logic [2:0]       c;

        // Zero acts as one, anything above the maximum acts as the maximum
        if (r_in_ch == '0)
            nin = 4'd1;
        else if (r_in_ch > CNT_W'(MAX_IN_CH))
            nin = CNT_W'(MAX_IN_CH);
        else
            nin = r_in_ch;
        if (r_out_ch == '0)
            nout = 4'd1;
        else if (r_out_ch > CNT_W'(MAX_OUT_CH))
            nout = CNT_W'(MAX_OUT_CH);
        else
            nout = r_out_ch;

        q = '0;
        for (int m = 1; m <= NUM_CH; m++) begin
            if (7'(m) * {3'b0, nout} <= {3'b0, nin})
                q = DIV_W'(m);
        end
        even = 7'({3'b0, q} * {3'b0, nout});
        rem  = (even != {3'b0, nin});

        n_dec = '0;
        c     = '0;
        for (int k = 0; k < NUM_CH; k++) begin
            n_dec.div[k]    = 4'd1;
            n_dec.out_en[k] = (CNT_W'(k) < nout);
        end

        if (nin > nout) begin
            // Fold inputs round-robin onto the outputs; on a remainder, spread the last input to all
            for (int j = 0; j < NUM_CH; j++) begin
                for (int k = 0; k < NUM_CH; k++) begin
                    if ((7'(j) < even) && (c == 3'(k)))
                        n_dec.mask[k][j] = 1'b1;
                    if (rem && (CNT_W'(j) == nin - 4'd1) && (CNT_W'(k) < nout))
                        n_dec.mask[k][j] = 1'b1;
                end
                c = (c == 3'(nout - 4'd1)) ? 3'd0 : c + 3'd1;
            end
            for (int k = 0; k < NUM_CH; k++) begin
                if (CNT_W'(k) < nout)
                    n_dec.div[k] = q;
            end
        end else if (nin < nout) begin
            // Copy the inputs, fill the extra outputs with the average
            for (int k = 0; k < NUM_CH; k++) begin
                if (CNT_W'(k) < nin) begin
                    n_dec.mask[k][k] = 1'b1;
                end else if (CNT_W'(k) < nout) begin
                    for (int j = 0; j < NUM_CH; j++)
                        n_dec.mask[k][j] = (CNT_W'(j) < nin);
                    n_dec.div[k] = nin;
                end
            end
        end else begin
            for (int k = 0; k < NUM_CH; k++) begin
                if (CNT_W'(k) < nout)
                    n_dec.mask[k][k] = 1'b1;
            end
        end
    end

    // Registered: follows the count registers in the next cycle
    always_ff @(posedge i_clk) begin
        r_dec <= n_dec;
    end

    assign o_dec = r_dec;

endmodule

/* rtl/acr_sum.sv */
module acr_sum import acr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mix_dec i_dec,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_sample  i_samples [NUM_CH],
    output logic     o_valid,
    input  logic     i_ready,
    output t_acc     o_acc [NUM_CH]
);

    logic [2:0] r_vld;
    logic [2:0] rdy;

    t_sample                    r_s1 [NUM_CH];
    logic signed [PAIR_W-1:0]   r_p2 [NUM_CH][NUM_CH/2];
    logic signed [PAIR_W-1:0]   n_p2 [NUM_CH][NUM_CH/2];
    t_acc                       r_a3 [NUM_CH];
    t_acc                       n_a3 [NUM_CH];

    assign rdy[2]  = !r_vld[2] || i_ready;
    assign rdy[1]  = !r_vld[1] || rdy[2];
    assign rdy[0]  = !r_vld[0] || rdy[1];
    assign o_ready = rdy[0];
    assign o_valid = r_vld[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) r_vld[0] <= i_valid;
            if (rdy[1]) r_vld[1] <= r_vld[0];
            if (rdy[2]) r_vld[2] <= r_vld[1];
        end
    end

    // Masked pair sums
    always_comb begin
        logic signed [PAIR_W-1:0] a;
        logic signed [PAIR_W-1:0] b;
        for (int k = 0; k < NUM_CH; k++) begin
            for (int i = 0; i < NUM_CH/2; i++) begin
                a = i_dec.mask[k][2*i]   ? PAIR_W'(r_s1[2*i])   : '0;
                b = i_dec.mask[k][2*i+1] ? PAIR_W'(r_s1[2*i+1]) : '0;
                n_p2[k][i] = a + b;
            end
        end
    end

    always_comb begin
        for (int k = 0; k < NUM_CH; k++) begin
            n_a3[k] = ACC_W'(r_p2[k][0]) + ACC_W'(r_p2[k][1])
                    + ACC_W'(r_p2[k][2]) + ACC_W'(r_p2[k][3]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0] && i_valid)
            r_s1 <= i_samples;
        if (rdy[1] && r_vld[0])
            r_p2 <= n_p2;
        if (rdy[2] && r_vld[1])
            r_a3 <= n_a3;
    end

    assign o_acc = r_a3;

endmodule

/* rtl/acr_div.sv */
`include "audio_channel_remixer_unit_macros.svh"

module acr_div import acr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mix_dec i_dec,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_acc     i_acc [NUM_CH],
    output logic     o_valid,
    input  logic     i_ready,
    output t_sample  o_samples [NUM_CH]
);

    logic [2:0] r_vld;
    logic [2:0] rdy;

    logic [MAG_W-1:0]    r_x4 [NUM_CH];
    logic [MAG_W-1:0]    n_x4 [NUM_CH];
    logic [NUM_CH-1:0]   r_neg4;
    logic [NUM_CH-1:0]   n_neg4;
    logic [MAG_W-1:0]    r_q5 [NUM_CH];
    logic [MAG_W-1:0]    n_q5 [NUM_CH];
    logic [NUM_CH-1:0]   r_neg5;
    t_sample             r_out [NUM_CH];
    t_sample             n_out [NUM_CH];

    // ceil(2^24 / d); exact for every magnitude this block can produce
    function automatic logic [RECIP_W-1:0] recip(input logic [DIV_W-1:0] d);
        logic [RECIP_W-1:0] r;
        case (d)
            4'd2:    r = 25'd8388608;
            4'd3:    r = 25'd5592406;
            4'd4:    r = 25'd4194304;
            4'd5:    r = 25'd3355444;
            4'd6:    r = 25'd2796203;
            4'd7:    r = 25'd2396746;
            4'd8:    r = 25'd2097152;
            default: r = 25'd16777216;
        endcase
        return r;
    endfunction

    assign rdy[2]  = !r_vld[2] || i_ready;
    assign rdy[1]  = !r_vld[1] || rdy[2];
    assign rdy[0]  = !r_vld[0] || rdy[1];
    assign o_ready = rdy[0];
    assign o_valid = r_vld[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) r_vld[0] <= i_valid;
            if (rdy[1]) r_vld[1] <= r_vld[0];
            if (rdy[2]) r_vld[2] <= r_vld[1];
        end
    end

    // Magnitude plus half the divisor: round half away from zero
    always_comb begin
        logic [MAG_W-1:0] a;
        for (int k = 0; k < NUM_CH; k++) begin
            a         = {i_acc[k][ACC_W-1], i_acc[k]};
            n_neg4[k] = i_acc[k][ACC_W-1];
            if (n_neg4[k])
                a = ~a + 1'b1;
            n_x4[k] = a + MAG_W'(i_dec.div[k][DIV_W-1:1]);
        end
    end

    always_comb begin
        logic [PROD_W-1:0] p;
        for (int k = 0; k < NUM_CH; k++) begin
            p       = r_x4[k] * recip(i_dec.div[k]);
            n_q5[k] = p[RECIP_SHIFT +: MAG_W];
        end
    end

    // Restore the sign and saturate
    always_comb begin
        logic [MAG_W-1:0] t;
        for (int k = 0; k < NUM_CH; k++) begin
            t = ~r_q5[k] + 1'b1;
            if (r_neg5[k])
                n_out[k] = (r_q5[k] > SAT_NEG_MAG) ? SAT_NEG : t[SAMPLE_W-1:0];
            else
                n_out[k] = (r_q5[k] > SAT_POS_MAG) ? SAT_POS : r_q5[k][SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0] && i_valid) begin
            r_x4   <= n_x4;
            r_neg4 <= n_neg4;
        end
        if (rdy[1] && r_vld[0]) begin
            r_q5   <= n_q5;
            r_neg5 <= r_neg4;
        end
        if (rdy[2] && r_vld[1])
            r_out <= n_out;
    end

    assign o_samples = r_out;

    `ACR_ASSERT_IMP(a_unused_zero, i_clk, i_rst_n, r_vld[2] && !i_dec.out_en[NUM_CH-1], r_out[NUM_CH-1] == '0)
    `ACR_ASSERT_ALWAYS(a_div_range, i_clk, i_rst_n, (i_dec.div[0] != '0) && (i_dec.div[0] <= DIV_MAX))
    `ACR_ASSERT_IMP(a_full_stall, i_clk, i_rst_n, r_vld[2] && !i_ready && r_vld[1] && r_vld[0], !o_ready)

endmodule

/* rtl/audio_channel_remixer_unit.sv */
// Audio channel remixer: takes one frame of eight signed 16-bit samples per
// item and returns one remixed frame per item, downmixing (grouped sums
// divided by in/out, the odd last channel spread to all outputs), upmixing
// (copies plus the rounded average of the inputs) or passing through,
// with round-half-away division and 16-bit saturation. Output channels at or
// above the configured count read zero. One frame is accepted every cycle
// unless m_axis_tready stalls the pipeline; a frame reaches m_axis_tvalid
// through three summing and three divide and saturate stages. Write the
// channel counts (index 0: inputs, index 1: outputs, 1..8, zero acts as one)
// only while no frame is in flight; a write takes effect for frames accepted
// from the next cycle on.
module audio_channel_remixer_unit import acr_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // in_sample_0 [15:0] up to in_sample_7 [127:112]
    input  logic [NUM_CH*SAMPLE_W-1:0]   s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // out_sample_0 [15:0] up to out_sample_7 [127:112]
    output logic [NUM_CH*SAMPLE_W-1:0]   m_axis_tdata,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_idx,
    input  logic [CNT_W-1:0]             i_cfg_data
);

    t_mix_dec dec;
    t_sample  in_s  [NUM_CH];
    t_sample  out_s [NUM_CH];
    t_acc     acc   [NUM_CH];
    logic     acc_valid;
    logic     acc_ready;

    always_comb begin
        for (int k = 0; k < NUM_CH; k++) begin
            in_s[k] = s_axis_tdata[k*SAMPLE_W +: SAMPLE_W];
            m_axis_tdata[k*SAMPLE_W +: SAMPLE_W] = out_s[k];
        end
    end

    acr_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_dec      (dec)
    );

    acr_sum u_sum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_dec     (dec),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_samples (in_s),
        .o_valid   (acc_valid),
        .i_ready   (acc_ready),
        .o_acc     (acc)
    );

    acr_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_dec     (dec),
        .i_valid   (acc_valid),
        .o_ready   (acc_ready),
        .i_acc     (acc),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_samples (out_s)
    );

endmodule

/* tb/audio_channel_remixer_unit_tb.sv */
module audio_channel_remixer_unit_tb import acr_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SMP_MAX    = 32767;
    localparam int SMP_MIN    = -32768;
    localparam int LONG_HOLD  = 300;

    typedef logic [NUM_CH*SAMPLE_W-1:0] t_frame;

    logic               i_clk;
    logic               i_rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    t_frame             s_axis_tdata;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    t_frame             m_axis_tdata;
    logic               i_cfg_we;
    logic               i_cfg_idx;
    logic [CNT_W-1:0]   i_cfg_data;

    // channel counts as last written to the block
    logic [CNT_W-1:0]   cfg_in_ch;
    logic [CNT_W-1:0]   cfg_out_ch;

    t_frame             mixed_frames_due[$];
    int                 mismatch_count;
    bit                 src_idle_en;
    bit                 sink_idle_en;
    bit                 long_hold_req;

    audio_channel_remixer_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int channel_count(input logic [CNT_W-1:0] raw, input int max_ch);
        if (raw == '0)
            return 1;
        if (int'(raw) > max_ch)
            return max_ch;
        return int'(raw);
    endfunction

    // round to nearest, ties away from zero
    function automatic int round_div(input int num, input int den);
        if (num >= 0)
            return (num + den / 2) / den;
        return -((-num + den / 2) / den);
    endfunction

    function automatic t_frame remix_frame(input t_frame frame,
                                           input logic [CNT_W-1:0] in_reg,
                                           input logic [CNT_W-1:0] out_reg);
        int smp [NUM_CH];
        int acc [NUM_CH];
        int n_in;
        int n_out;
        int even;
        int quot;
        int total;
        int avg;
        t_frame mixed;
        n_in  = channel_count(in_reg, MAX_IN_CH);
        n_out = channel_count(out_reg, MAX_OUT_CH);
        for (int j = 0; j < NUM_CH; j++) begin
            smp[j] = int'(t_sample'(frame[j*SAMPLE_W +: SAMPLE_W]));
            acc[j] = 0;
        end
        if (n_in > n_out) begin
            even = n_in - (n_in % n_out);
            quot = n_in / n_out;
            for (int j = 0; j < even; j++)
                acc[j % n_out] += smp[j];
            // spread the odd last channel over every output
            if (even != n_in) begin
                for (int j = 0; j < n_out; j++)
                    acc[j] += smp[n_in-1];
            end
            for (int j = 0; j < n_out; j++)
                acc[j] = round_div(acc[j], quot);
        end else if (n_in < n_out) begin
            total = 0;
            for (int j = 0; j < n_in; j++)
                total += smp[j];
            avg = round_div(total, n_in);
            for (int j = 0; j < n_out; j++)
                acc[j] = (j < n_in) ? smp[j] : avg;
        end else begin
            for (int j = 0; j < n_out; j++)
                acc[j] = smp[j];
        end
        mixed = '0;
        for (int j = 0; j < n_out; j++) begin
            if (acc[j] > SMP_MAX)
                acc[j] = SMP_MAX;
            else if (acc[j] < SMP_MIN)
                acc[j] = SMP_MIN;
            mixed[j*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'(acc[j]);
        end
        return mixed;
    endfunction

    function automatic logic [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 7))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return SAMPLE_W'($urandom_range(0, 8) - 4);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic t_frame random_frame();
        t_frame frame;
        for (int j = 0; j < NUM_CH; j++)
            frame[j*SAMPLE_W +: SAMPLE_W] = random_sample();
        return frame;
    endfunction

    function automatic logic [CNT_W-1:0] random_count();
        if ($urandom_range(0, 9) == 0)
            return CNT_W'($urandom_range(0, 15));
        return CNT_W'($urandom_range(1, 8));
    endfunction

    // call at a falling edge; leaves tvalid high for the next item
    task automatic send_frame(input t_frame frame);
        int gap;
        gap = 0;
        if (src_idle_en && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 16);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= frame;
        do @(posedge i_clk); while (!s_axis_tready);
        mixed_frames_due.push_back(remix_frame(frame, cfg_in_ch, cfg_out_ch));
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (mixed_frames_due.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic set_counts(input logic [CNT_W-1:0] n_in, input logic [CNT_W-1:0] n_out);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_IN_CHANNELS;
        i_cfg_data <= n_in;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_OUT_CHANNELS;
        i_cfg_data <= n_out;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_in_ch  = n_in;
        cfg_out_ch = n_out;
    endtask

    task automatic test_directed();
        t_frame frame;
        // reset counts: two in, two out
        send_frame('0);
        send_frame({NUM_CH{16'h7fff}});
        send_frame({NUM_CH{16'h8000}});
        set_counts(4'd8, 4'd1);
        send_frame({NUM_CH{16'h7fff}});
        send_frame({NUM_CH{16'h8000}});
        // remainder: last input goes to both outputs
        set_counts(4'd7, 4'd2);
        send_frame({NUM_CH{16'h7fff}});
        send_frame(random_frame());
        // remainder with saturation both ways
        set_counts(4'd8, 4'd3);
        send_frame({NUM_CH{16'h7fff}});
        send_frame({NUM_CH{16'h8000}});
        // average ties: +0.5 and -0.5
        set_counts(4'd2, 4'd4);
        frame = random_frame();
        frame[31:0] = {16'd0, 16'd1};
        send_frame(frame);
        frame[31:0] = {16'd0, 16'hffff};
        send_frame(frame);
        set_counts(4'd1, 4'd8);
        send_frame({NUM_CH{16'h8000}});
        set_counts(4'd3, 4'd8);
        send_frame({NUM_CH{16'h7fff}});
        send_frame({NUM_CH{16'h8000}});
        // zero acts as one, above eight acts as eight
        set_counts(4'd0, 4'd0);
        send_frame(random_frame());
        set_counts(4'd15, 4'd15);
        send_frame(random_frame());
        set_counts(4'd9, 4'd0);
        send_frame(random_frame());
        set_counts(4'd0, 4'd12);
        send_frame(random_frame());
    endtask

    task automatic test_random_mix();
        int phase_len;
        for (int p = 0; p < 28; p++) begin
            case (p)
                0: set_counts(4'd1, 4'd8);
                1: set_counts(4'd8, 4'd1);
                2: set_counts(4'd8, 4'd8);
                3: set_counts(4'd1, 4'd1);
                default: set_counts(random_count(), random_count());
            endcase
            phase_len = $urandom_range(15, 55);
            for (int k = 0; k < phase_len; k++) begin
                // hold the sender until everything is back, now and then
                if (k == phase_len / 2 && $urandom_range(0, 3) == 0)
                    wait_drained();
                send_frame(random_frame());
            end
        end
    endtask

    task automatic test_backpressure();
        set_counts(4'd6, 4'd2);
        src_idle_en   = 1'b0;
        long_hold_req = 1'b1;
        for (int k = 0; k < 80; k++)
            send_frame(random_frame());
        src_idle_en = 1'b1;
    endtask

    task automatic test_full_rate();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        set_counts(4'd5, 4'd3);
        for (int k = 0; k < 100; k++)
            send_frame(random_frame());
        set_counts(4'd2, 4'd7);
        for (int k = 0; k < 60; k++)
            send_frame(random_frame());
    endtask

    // output ready: random low bursts, one long hold on request
    initial begin
        bit level;
        int span;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                level = 1'b0;
                span  = LONG_HOLD;
                long_hold_req = 1'b0;
            end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
                level = 1'b0;
                span  = $urandom_range(1, 16);
            end else begin
                level = 1'b1;
                span  = sink_idle_en ? $urandom_range(1, 24) : 1;
            end
            m_axis_tready <= level;
            repeat (span - 1) @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_frame want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (mixed_frames_due.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected item, expected none, got %h", $time, m_axis_tdata);
            end else begin
                want = mixed_frames_due.pop_front();
                for (int k = 0; k < NUM_CH; k++) begin
                    if (m_axis_tdata[k*SAMPLE_W +: SAMPLE_W] !== want[k*SAMPLE_W +: SAMPLE_W]) begin
                        mismatch_count++;
                        $display("%0t: out_sample_%0d expected %h got %h", $time, k,
                                 want[k*SAMPLE_W +: SAMPLE_W],
                                 m_axis_tdata[k*SAMPLE_W +: SAMPLE_W]);
                    end
                end
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_IN_CHANNELS;
        i_cfg_data     = '0;
        cfg_in_ch      = CNT_RESET;
        cfg_out_ch     = CNT_RESET;
        mismatch_count = 0;
        src_idle_en    = 1'b1;
        sink_idle_en   = 1'b1;
        long_hold_req  = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_random_mix();
        test_backpressure();
        test_full_rate();
        wait_drained();

        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/acr_pkg.sv
rtl/acr_cfg.sv
rtl/acr_sum.sv
rtl/acr_div.sv
rtl/audio_channel_remixer_unit.sv
tb/audio_channel_remixer_unit_tb.sv
